@@ hw/rtl/utcp_pkg.sv @@
`timescale 1ns / 1ps

package utcp_pkg;

  localparam int unsigned FULL_LEN = 19;

  localparam logic [4:0] POS_SEP_DATE1 = 5'd4;
  localparam logic [4:0] POS_SEP_DATE2 = 5'd7;
  localparam logic [4:0] POS_SEP_SPACE = 5'd10;
  localparam logic [4:0] POS_SEP_TIME1 = 5'd13;
  localparam logic [4:0] POS_SEP_TIME2 = 5'd16;
  localparam logic [4:0] POS_FULL      = 5'(FULL_LEN);

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [5:0] SECOND_LIMIT_RESET = 6'd61;

  typedef struct packed {
    logic [13:0] year;
    logic [15:0] year_digits;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } utcp_acc_t;

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] d);
    logic [10:0] prod;
    prod = 11'(a) * 11'd10 + 11'(d);
    return prod[6:0];
  endfunction

  function automatic logic [13:0] acc_year(input logic [13:0] a, input logic [3:0] d);
    logic [17:0] prod;
    prod = 18'(a) * 18'd10 + 18'(d);
    return prod[13:0];
  endfunction

  // Leap year from the four BCD digits: century years need the first two
  // digits divisible by four, the rest the last two.
  function automatic logic is_leap(input logic [15:0] digits);
    logic [5:0] hi_mod;
    logic [5:0] lo_mod;
    hi_mod = {1'b0, digits[15:12], 1'b0} + {2'b00, digits[11:8]};
    lo_mod = {1'b0, digits[7:4], 1'b0} + {2'b00, digits[3:0]};
    if (digits[7:0] == 8'h00) begin
      return hi_mod[1:0] == 2'b00;
    end
    return lo_mod[1:0] == 2'b00;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] dim;
    unique case (month)
      4'd2:                      dim = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   dim = 5'd30;
      default:                   dim = 5'd31;
    endcase
    return dim;
  endfunction

endpackage

@@ hw/rtl/utcp_check.sv @@
`timescale 1ns / 1ps

module utcp_check (
  input  utcp_pkg::utcp_acc_t acc,
  input  logic [4:0]          char_position,
  input  logic                format_error,
  input  logic [5:0]          second_limit,
  output logic                ok
);
  import utcp_pkg::*;

  logic       leap;
  logic [4:0] dim;
  logic       month_ok;
  logic       day_ok;
  logic       time_ok;

  always_comb begin
    leap     = is_leap(acc.year_digits);
    dim      = days_in_month(acc.month[3:0], leap);
    month_ok = (acc.month >= 7'd1) && (acc.month <= 7'd12);
    day_ok   = (acc.day >= 7'd1) && (acc.day <= {2'b00, dim});
    time_ok  = (acc.hour < 7'd24) && (acc.minute < 7'd60) &&
               (acc.second < {1'b0, second_limit});
    ok = !format_error && (char_position == POS_FULL) && month_ok && day_ok && time_ok;
  end

endmodule

@@ hw/rtl/utc_timestamp_parser_core.sv @@
`timescale 1ns / 1ps
// A terminating zero byte is taken into the input register; its result is then registered in the output register.
// Throughput: one character per cycle; the input register holds a zero byte
// only while the single output register is full and stalled.
// Reset (rst, synchronous): position and accumulators clear, output empty,
// second_limit returns to 61.

module utc_timestamp_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        second_limit_we,
  input  logic [5:0]  second_limit_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_valid,
  output logic [13:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);
  import utcp_pkg::*;

  logic [5:0] second_limit;
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_hold;
  logic       s1_go;
  logic       s1_term;

  logic [4:0] char_position;
  logic [4:0] char_position_next;
  logic       format_error;
  logic       format_error_next;
  utcp_acc_t  acc;
  utcp_acc_t  acc_next;
  logic       ok;

  logic       is_sep;
  logic [7:0] want;
  logic       is_digit;
  logic [3:0] digit;

  assign s1_term  = (s1_char == CHAR_NUL);
  assign s1_hold  = s1_term && out_valid && out_stall;
  assign s1_go    = s1_valid && !s1_hold;
  assign in_stall = s1_valid && s1_hold;

  always_comb begin
    is_sep = (char_position == POS_SEP_DATE1) || (char_position == POS_SEP_DATE2) ||
             (char_position == POS_SEP_SPACE) || (char_position == POS_SEP_TIME1) ||
             (char_position == POS_SEP_TIME2);
    priority if (char_position == POS_SEP_SPACE) begin
      want = CHAR_SPACE;
    end else if (char_position < POS_SEP_SPACE) begin
      want = CHAR_DASH;
    end else begin
      want = CHAR_COLON;
    end
    is_digit = (s1_char >= CHAR_ZERO) && (s1_char <= CHAR_NINE);
    digit    = 4'(s1_char - CHAR_ZERO);

    char_position_next = char_position;
    format_error_next  = format_error;
    acc_next           = acc;

    if (s1_term) begin
      char_position_next = '0;
      format_error_next  = 1'b0;
      acc_next           = '0;
    end else if (char_position >= POS_FULL) begin
      format_error_next  = 1'b1;
      char_position_next = POS_FULL;
    end else begin
      char_position_next = char_position + 5'd1;
      if (is_sep) begin
        if (s1_char != want) begin
          format_error_next = 1'b1;
        end
      end else if (!is_digit) begin
        format_error_next = 1'b1;
      end else begin
        priority if (char_position < POS_SEP_DATE1) begin
          acc_next.year        = acc_year(acc.year, digit);
          acc_next.year_digits = {acc.year_digits[11:0], digit};
        end else if (char_position < POS_SEP_DATE2) begin
          acc_next.month = acc2(acc.month, digit);
        end else if (char_position < POS_SEP_SPACE) begin
          acc_next.day = acc2(acc.day, digit);
        end else if (char_position < POS_SEP_TIME1) begin
          acc_next.hour = acc2(acc.hour, digit);
        end else if (char_position < POS_SEP_TIME2) begin
          acc_next.minute = acc2(acc.minute, digit);
        end else begin
          acc_next.second = acc2(acc.second, digit);
        end
      end
    end
  end

  utcp_check u_check (
    .acc           (acc),
    .char_position (char_position),
    .format_error  (format_error),
    .second_limit  (second_limit),
    .ok            (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      second_limit <= SECOND_LIMIT_RESET;
    end else if (second_limit_we) begin
      second_limit <= second_limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_char <= char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      format_error  <= 1'b0;
      acc           <= '0;
    end else if (s1_go) begin
      char_position <= char_position_next;
      format_error  <= format_error_next;
      acc           <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_term) begin
      is_valid   <= ok;
      year_out   <= ok ? acc.year : '0;
      month_out  <= ok ? acc.month[3:0] : '0;
      day_out    <= ok ? acc.day[4:0] : '0;
      hour_out   <= ok ? acc.hour[4:0] : '0;
      minute_out <= ok ? acc.minute[5:0] : '0;
      second_out <= ok ? acc.second[5:0] : '0;
    end
  end

endmodule

@@ verif/utc_timestamp_parser_core_test.sv @@
`timescale 1ns / 1ps

module utc_timestamp_parser_core_test;
  import utcp_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef enum int {FLAW_NONE, FLAW_CHAR, FLAW_SHORT, FLAW_LONG, FLAW_NOISE} flaw_e;
  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        second_limit_we = 1'b0;
  logic [5:0]  second_limit_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_valid;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  utc_timestamp_parser_core dut (
    .clk                (clk),
    .rst                (rst),
    .second_limit_we    (second_limit_we),
    .second_limit_wdata (second_limit_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .char_byte          (char_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .is_valid           (is_valid),
    .year_out           (year_out),
    .month_out          (month_out),
    .day_out            (day_out),
    .hour_out           (hour_out),
    .minute_out         (minute_out),
    .second_out         (second_out)
  );

  always #5 clk = ~clk;

  logic [7:0]  char_q[$];
  stamp_t      pending_stamps[$];
  int unsigned chars_queued = 0;
  int unsigned stamps_seen = 0;
  int unsigned mismatch_count = 0;
  bit          in_taken = 1'b0;
  bit          hold_long = 1'b0;

  // parser shadow state
  logic [5:0]  sec_limit = SECOND_LIMIT_RESET;
  logic [4:0]  pos = '0;
  bit          fmt_err = 1'b0;
  logic [13:0] yr_acc = '0;
  logic [6:0]  mon_acc = '0;
  logic [6:0]  day_acc = '0;
  logic [6:0]  hr_acc = '0;
  logic [6:0]  min_acc = '0;
  logic [6:0]  sec_acc = '0;

  task automatic flag_error(input string what);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input bit leap);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    stamp_t      want;
    bit          ok;
    logic [7:0]  sep;
    logic [3:0]  d;
    if (c == CHAR_NUL) begin
      ok = !fmt_err && pos == POS_FULL;
      if (ok && (mon_acc < 1 || mon_acc > 12)) ok = 1'b0;
      if (ok && (day_acc < 1 || day_acc > month_days(mon_acc, leap_year(yr_acc)))) ok = 1'b0;
      if (ok && (hr_acc >= 24 || min_acc >= 60 || sec_acc >= sec_limit)) ok = 1'b0;
      want = '0;
      if (ok) begin
        want = {1'b1, yr_acc, mon_acc[3:0], day_acc[4:0], hr_acc[4:0], min_acc[5:0],
                sec_acc[5:0]};
      end
      pending_stamps.push_back(want);
      pos = '0;
      fmt_err = 1'b0;
      yr_acc = '0;
      mon_acc = '0;
      day_acc = '0;
      hr_acc = '0;
      min_acc = '0;
      sec_acc = '0;
    end else if (pos >= POS_FULL) begin
      fmt_err = 1'b1;
      pos = POS_FULL;
    end else begin
      if (pos == POS_SEP_DATE1 || pos == POS_SEP_DATE2 || pos == POS_SEP_SPACE ||
          pos == POS_SEP_TIME1 || pos == POS_SEP_TIME2) begin
        sep = (pos == POS_SEP_SPACE) ? CHAR_SPACE :
              (pos < POS_SEP_SPACE) ? CHAR_DASH : CHAR_COLON;
        if (c != sep) fmt_err = 1'b1;
      end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
        fmt_err = 1'b1;
      end else begin
        d = 4'(c - CHAR_ZERO);
        if (pos < POS_SEP_DATE1) yr_acc = 14'(yr_acc * 10 + d);
        else if (pos < POS_SEP_DATE2) mon_acc = 7'(mon_acc * 10 + d);
        else if (pos < POS_SEP_SPACE) day_acc = 7'(day_acc * 10 + d);
        else if (pos < POS_SEP_TIME1) hr_acc = 7'(hr_acc * 10 + d);
        else if (pos < POS_SEP_TIME2) min_acc = 7'(min_acc * 10 + d);
        else sec_acc = 7'(sec_acc * 10 + d);
      end
      pos = pos + 1'b1;
    end
  endfunction

  // monitor: accepted input feeds the shadow parser, accepted output is checked
  always @(posedge clk) begin : monitor
    stamp_t got;
    stamp_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        parse_char(char_byte);
      end
      if (out_valid && !out_stall) begin
        stamps_seen++;
        got = {is_valid, year_out, month_out, day_out, hour_out, minute_out, second_out};
        if (pending_stamps.size() == 0) begin
          flag_error($sformatf("unexpected result %0d %0d-%0d-%0d %0d:%0d:%0d", got.ok,
                               got.year, got.month, got.day, got.hour, got.minute,
                               got.second));
        end else begin
          want = pending_stamps.pop_front();
          if (got.ok !== want.ok || got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second) begin
            flag_error($sformatf("got %0d %0d-%0d-%0d %0d:%0d:%0d want %0d %0d-%0d-%0d %0d:%0d:%0d",
                                 got.ok, got.year, got.month, got.day, got.hour,
                                 got.minute, got.second, want.ok, want.year, want.month,
                                 want.day, want.hour, want.minute, want.second));
          end
        end
      end
    end
  end

  // driver: bursts of characters with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (char_q.size() > 0) begin
        in_valid <= 1'b1;
        char_byte <= char_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_run = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk) begin : stall_gen
    bit pat;
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run = $urandom_range(4, 50);
    end else begin
      stall_run--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     pat = 1'b0;
      STALL_COIN:     pat = $urandom_range(0, 1);
      STALL_PERIODIC: pat = (stall_tick % 4) != 0;
      default:        pat = ($urandom_range(0, 7) == 0);
    endcase
    out_stall <= hold_long || pat;
  end

  // long hold-off so the output register fills and backs up the input
  initial begin
    wait (stamps_seen >= 30);
    @(posedge clk);
    hold_long = 1'b1;
    repeat (150) @(posedge clk);
    hold_long = 1'b0;
  end

  task automatic push_byte(input logic [7:0] b);
    char_q.push_back(b);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    push_byte(CHAR_NUL);
  endtask

  task automatic random_line();
    logic [7:0]  text[$];
    string       s;
    int unsigned y, m, d, h, mi, sc, dim, n, r;
    flaw_e       flaw;
    case ($urandom_range(0, 3))
      0:       y = 100 * $urandom_range(0, 99);
      1:       y = 4 * $urandom_range(0, 2499);
      default: y = $urandom_range(0, 9999);
    endcase
    if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
    else m = $urandom_range(1, 12);
    dim = (m >= 1 && m <= 12) ? month_days(m, leap_year(y)) : 31;
    r = $urandom_range(0, 9);
    if (r < 6) d = $urandom_range(1, dim);
    else if (r == 6) d = dim;
    else if (r == 7) d = dim + 1;
    else if (r == 8) d = 0;
    else d = $urandom_range(0, 99);
    h = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    r = $urandom_range(0, 7);
    if (r < 5) sc = $urandom_range(0, 59);
    else if (r < 7) sc = $urandom_range(58, 63);
    else sc = $urandom_range(64, 99);
    s = $sformatf("%04d-%02d-%02d %02d:%02d:%02d", y, m, d, h, mi, sc);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    r = $urandom_range(0, 9);
    flaw = (r < 6) ? FLAW_NONE : (r == 6) ? FLAW_CHAR : (r == 7) ? FLAW_SHORT :
           (r == 8) ? FLAW_LONG : FLAW_NOISE;
    case (flaw)
      FLAW_CHAR:  text[$urandom_range(0, 18)] = 8'($urandom_range(1, 255));
      FLAW_SHORT: begin
        n = $urandom_range(0, 18);
        while (text.size() > n) void'(text.pop_back());
      end
      FLAW_LONG:  repeat ($urandom_range(1, 16)) text.push_back(8'($urandom_range(1, 255)));
      FLAW_NOISE: begin
        text.delete();
        repeat ($urandom_range(0, 24)) text.push_back(8'($urandom_range(1, 255)));
      end
      default: ;
    endcase
    foreach (text[k]) push_byte(text[k]);
    push_byte(CHAR_NUL);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while ((char_q.size() != 0 || in_valid || pending_stamps.size() != 0) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    @(negedge clk);
    second_limit_we <= 1'b1;
    second_limit_wdata <= v;
    @(negedge clk);
    second_limit_we <= 1'b0;
    sec_limit = v;
  endtask

  initial begin
    logic [5:0]  limits [5];
    int unsigned phase_end;
    limits = '{6'd60, 6'd0, 6'd63, 6'd62, 6'd61};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_line("2000-02-29 23:59:60");
    push_line("1900-02-29 12:00:00");
    push_line("2024-02-29 00:00:00");
    push_line("2023-02-29 00:00:00");
    push_line("0000-01-01 00:00:00");
    push_line("9999-12-31 23:59:59");
    push_line("2021-00-10 10:10:10");
    push_line("2021-13-10 10:10:10");
    push_line("2021-04-31 10:10:10");
    push_line("2021-04-00 10:10:10");
    push_line("2021-06-15 24:00:00");
    push_line("2021-06-15 23:60:00");
    push_line("2021-06-15 23:59:61");
    push_line("");
    push_line("2021-06-15");
    push_line("2021-06-15 01:02:033");
    push_line("2021/06-15 01:02:03");
    push_line("20a1-06-15 01:02:03");
    push_line("2021-06-15T01:02:03");
    push_text("2021-06-15 01:02:0");
    push_byte(8'hFF);
    push_byte(CHAR_NUL);
    push_text("2021-06-15 01:02:03");
    push_byte(8'h80);
    push_line("99999999999999");
    drain();

    foreach (limits[i]) begin
      write_limit(limits[i]);
      phase_end = chars_queued + 80;
      while (chars_queued < phase_end) random_line();
      drain();
    end

    if (pending_stamps.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_stamps.size()));
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/utcp_pkg.sv
hw/rtl/utcp_check.sv
hw/rtl/utc_timestamp_parser_core.sv
verif/utc_timestamp_parser_core_test.sv
